@@ rtl/rdd_pkg.sv @@
// ----------------------------------------------------------------------------
// rdd_pkg
// Shared constants and types for the resource deadlock detector.
// ----------------------------------------------------------------------------
package rdd_pkg;

    localparam int MAX_PROCESSES  = 16;
    localparam int RESOURCE_TYPES = 3;
    localparam int LANES          = 4;
    localparam int IDX_W          = $clog2(MAX_PROCESSES);
    localparam int CNT_W          = $clog2(MAX_PROCESSES + 1);
    localparam int ID_W           = 22;
    localparam int UNIT_W         = 8;
    localparam int WORK_W         = 9;
    localparam logic [UNIT_W-1:0] DEFAULT_UNITS = 8'd9;

    typedef logic [UNIT_W-1:0] units_t [LANES];
    typedef logic [WORK_W-1:0] work_t  [LANES];

    typedef enum logic [1:0] {
        OP_ADMIT  = 2'd0,
        OP_TERM   = 2'd1,
        OP_DETECT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_WAITING   = 3'd1,
        ST_FULL      = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_TERMINATED = 3'd4,
        ST_NO_DEADLOCK = 3'd5,
        ST_DEADLOCK  = 3'd6,
        ST_CLEARED   = 3'd7
    } status_t;

    // one lane's verdict for one table entry
    typedef struct packed {
        logic fits;
        logic [WORK_W-1:0] sum;
    } lane_res_t;

endpackage

@@ rtl/resource_deadlock_detector_core.sv @@
// ----------------------------------------------------------------------------
// resource_deadlock_detector_core
// Banker-style deadlock detector with a compacting process table.
// ----------------------------------------------------------------------------
// flow: admit, clear, detect on an empty table and terminate of an unknown
//   id go straight to the result; terminate of a known id first compacts the
//   table, shifting down the entries after the removed one
// detect: one table entry per cycle, up to MAX_PROCESSES + 1 passes over the
//   table; one item at a time
// reset: available counts load 9 per type, table empty, register at 9
module resource_deadlock_detector_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [21:0]                   process_id,
    input  logic [7:0]                    req_0,
    input  logic [7:0]                    req_1,
    input  logic [7:0]                    req_2,
    input  logic [7:0]                    req_3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [21:0]                   found_id,
    output logic [7:0]                    avail_0,
    output logic [7:0]                    avail_1,
    output logic [7:0]                    avail_2,
    output logic [7:0]                    avail_3
);
    localparam int L  = rdd_pkg::LANES;
    localparam int IW = rdd_pkg::IDX_W;
    localparam int CW = rdd_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TERM   = 4'b0010,
        S_DETECT = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]                 init_reg;
    logic [7:0]                 avail_reg [L];
    logic [CW-1:0]              count_reg;
    logic [rdd_pkg::ID_W-1:0]   id_reg    [rdd_pkg::MAX_PROCESSES];
    logic [7:0]                 alloc_reg [rdd_pkg::MAX_PROCESSES][L];
    logic [7:0]                 reqr_reg  [rdd_pkg::MAX_PROCESSES][L];
    logic [rdd_pkg::MAX_PROCESSES-1:0] fin_reg;
    logic [rdd_pkg::WORK_W-1:0] work_reg  [L];
    logic [IW-1:0]              idx_reg;
    logic                       prog_reg;
    logic [2:0]                 status_reg;
    logic [21:0]                found_reg;

    logic [7:0] req_in [L];
    rdd_pkg::lane_res_t lane_res [L];
    logic lane_fit_all;

    assign req_in[0] = req_0;
    assign req_in[1] = req_1;
    assign req_in[2] = req_2;
    assign req_in[3] = req_3;

    // lanes: compare the scanned entry against the work vector
    for (genvar k = 0; k < L; k++)
    begin : g_lane
        rdd_lane u_lane
        (
            .used  (k < rdd_pkg::RESOURCE_TYPES),
            .work  (work_reg[k]),
            .req   (reqr_reg[idx_reg][k]),
            .alloc (alloc_reg[idx_reg][k]),
            .res   (lane_res[k])
        );
    end

    // merge the lane verdicts
    always_comb
    begin
        lane_fit_all = 1'b1;
        for (int k = 0; k < L; k++)
            lane_fit_all = lane_fit_all & lane_res[k].fits;
    end

    // admit fit check against available counts
    logic admit_fits;
    always_comb
    begin
        admit_fits = 1'b1;
        for (int k = 0; k < rdd_pkg::RESOURCE_TYPES; k++)
            if (req_in[k] > avail_reg[k])
                admit_fits = 1'b0;
    end

    // first match of the id for terminate
    logic            hit;
    logic [IW-1:0]   hit_idx;
    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        for (int i = rdd_pkg::MAX_PROCESSES - 1; i >= 0; i--)
            if ((CW'(i) < count_reg) && (id_reg[i] == process_id))
            begin
                hit = 1'b1;
                hit_idx = IW'(i);
            end
    end

    // first unfinished entry after detect
    logic            dl;
    logic [IW-1:0]   dl_idx;
    always_comb
    begin
        dl = 1'b0;
        dl_idx = '0;
        for (int i = rdd_pkg::MAX_PROCESSES - 1; i >= 0; i--)
            if ((CW'(i) < count_reg) && !fin_reg[i])
            begin
                dl = 1'b1;
                dl_idx = IW'(i);
            end
    end

    logic accept;
    logic last_idx;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign last_idx  = ({1'b0, idx_reg} + CW'(1)) >= count_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (rdd_pkg::op_t'(op))
                        rdd_pkg::OP_TERM:   state_next = hit ? S_TERM : S_OUT;
                        rdd_pkg::OP_DETECT: state_next = (count_reg == '0) ? S_OUT : S_DETECT;
                        default:            state_next = S_OUT;
                    endcase
                end
            end
            S_TERM:
            begin
                if (last_idx)
                    state_next = S_OUT;
            end
            S_DETECT:
            begin
                if (last_idx && !(prog_reg || (!fin_reg[idx_reg] && lane_fit_all)))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            init_reg  <= rdd_pkg::DEFAULT_UNITS;
            count_reg <= '0;
            for (int k = 0; k < L; k++)
                avail_reg[k] <= (k < rdd_pkg::RESOURCE_TYPES) ? rdd_pkg::DEFAULT_UNITS : 8'd0;
            fin_reg   <= '0;
            prog_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                init_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (rdd_pkg::op_t'(op))
                            rdd_pkg::OP_ADMIT:
                            begin
                                if (count_reg < CW'(rdd_pkg::MAX_PROCESSES))
                                begin
                                    count_reg <= count_reg + CW'(1);
                                    if (admit_fits)
                                        for (int k = 0; k < rdd_pkg::RESOURCE_TYPES; k++)
                                            avail_reg[k] <= avail_reg[k] - req_in[k];
                                end
                            end
                            rdd_pkg::OP_TERM:
                            begin
                                idx_reg <= hit_idx;
                                if (hit)
                                    for (int k = 0; k < rdd_pkg::RESOURCE_TYPES; k++)
                                        avail_reg[k] <= ({1'b0, avail_reg[k]}
                                            + {1'b0, alloc_reg[hit_idx][k]}) > 9'd255
                                            ? 8'd255 : avail_reg[k] + alloc_reg[hit_idx][k];
                            end
                            rdd_pkg::OP_DETECT:
                            begin
                                idx_reg  <= '0;
                                fin_reg  <= '0;
                                prog_reg <= 1'b0;
                            end
                            default:
                            begin
                                count_reg <= '0;
                                for (int k = 0; k < L; k++)
                                    avail_reg[k] <= (k < rdd_pkg::RESOURCE_TYPES) ? init_reg : 8'd0;
                            end
                        endcase
                    end
                end
                S_TERM:
                begin
                    if (last_idx)
                        count_reg <= count_reg - CW'(1);
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                S_DETECT:
                begin
                    if (!fin_reg[idx_reg] && lane_fit_all)
                        fin_reg[idx_reg] <= 1'b1;
                    if (last_idx)
                    begin
                        idx_reg  <= '0;
                        prog_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                        if (!fin_reg[idx_reg] && lane_fit_all)
                            prog_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // table, work vector and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // detect reports id 0 unless a stuck entry is found
                    found_reg <= (rdd_pkg::op_t'(op) == rdd_pkg::OP_DETECT) ? '0 : process_id;
                    case (rdd_pkg::op_t'(op))
                        rdd_pkg::OP_ADMIT:
                        begin
                            if (count_reg < CW'(rdd_pkg::MAX_PROCESSES))
                            begin
                                id_reg[count_reg[IW-1:0]] <= process_id;
                                for (int k = 0; k < L; k++)
                                begin
                                    alloc_reg[count_reg[IW-1:0]][k] <=
                                        (admit_fits && k < rdd_pkg::RESOURCE_TYPES) ? req_in[k] : 8'd0;
                                    reqr_reg[count_reg[IW-1:0]][k] <=
                                        (!admit_fits && k < rdd_pkg::RESOURCE_TYPES) ? req_in[k] : 8'd0;
                                end
                                status_reg <= admit_fits ? rdd_pkg::ST_ALLOCATED : rdd_pkg::ST_WAITING;
                            end
                            else
                                status_reg <= rdd_pkg::ST_FULL;
                        end
                        rdd_pkg::OP_TERM:
                            status_reg <= hit ? rdd_pkg::ST_TERMINATED : rdd_pkg::ST_UNKNOWN;
                        rdd_pkg::OP_DETECT:
                        begin
                            for (int k = 0; k < L; k++)
                                work_reg[k] <= {1'b0, avail_reg[k]};
                            status_reg <= rdd_pkg::ST_NO_DEADLOCK;
                        end
                        default:
                            status_reg <= rdd_pkg::ST_CLEARED;
                    endcase
                end
            end
            S_TERM:
            begin
                // shift the next entry down over the gap
                if (!last_idx)
                begin
                    id_reg[idx_reg] <= id_reg[idx_reg + IW'(1)];
                    for (int k = 0; k < L; k++)
                    begin
                        alloc_reg[idx_reg][k] <= alloc_reg[idx_reg + IW'(1)][k];
                        reqr_reg[idx_reg][k]  <= reqr_reg[idx_reg + IW'(1)][k];
                    end
                end
            end
            S_DETECT:
            begin
                if (!fin_reg[idx_reg] && lane_fit_all)
                    for (int k = 0; k < rdd_pkg::RESOURCE_TYPES; k++)
                        work_reg[k] <= lane_res[k].sum;
                if (state_next == S_OUT)
                begin
                    // last entry may finish this cycle; include it
                    if (dl && !(dl_idx == idx_reg && lane_fit_all))
                    begin
                        status_reg <= rdd_pkg::ST_DEADLOCK;
                        found_reg  <= id_reg[dl_idx];
                    end
                end
            end
            default: ;
        endcase
    end

    assign status   = status_reg;
    assign found_id = found_reg;
    assign avail_0  = avail_reg[0];
    assign avail_1  = avail_reg[1];
    assign avail_2  = avail_reg[2];
    assign avail_3  = avail_reg[3];
endmodule

@@ rtl/rdd_lane.sv @@
// ----------------------------------------------------------------------------
// rdd_lane
// One resource type: compares a request with a count and adds an allocation.
// ----------------------------------------------------------------------------
module rdd_lane
(
    input  logic                          used,
    input  logic [rdd_pkg::WORK_W-1:0]    work,
    input  logic [rdd_pkg::UNIT_W-1:0]    req,
    input  logic [rdd_pkg::UNIT_W-1:0]    alloc,
    output rdd_pkg::lane_res_t            res
);
    logic [rdd_pkg::WORK_W:0] sum_wide;

    // fit check and saturating add
    always_comb
    begin
        sum_wide = {1'b0, work} + {{(rdd_pkg::WORK_W-rdd_pkg::UNIT_W+1){1'b0}}, alloc};
        res.fits = !used || ({1'b0, req} <= work);
        res.sum  = sum_wide[rdd_pkg::WORK_W] ? {rdd_pkg::WORK_W{1'b1}}
                                             : sum_wide[rdd_pkg::WORK_W-1:0];
    end
endmodule
